### design/bdlp_pkg.sv
// Package for the button debounce / long-press block.
// Holds item and configuration types, register codes and reset values; no dependencies.
package bdlp_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DUR_W      = 16;

    localparam logic [DUR_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [DUR_W-1:0] HOLD_RESET     = 16'd1000;

    // Register index taken from the word address
    typedef enum logic {
        REG_DEBOUNCE = 1'b0,
        REG_HOLD     = 1'b1
    } t_reg_idx;

    // Item kind
    typedef enum logic {
        KIND_UPDATE  = 1'b0,
        KIND_RESTART = 1'b1
    } t_kind;

    typedef struct packed {
        logic              kind;
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
        logic              ack_long;
    } t_in_item;

    typedef struct packed {
        logic is_down;
        logic press_pulse;
        logic release_pulse;
        logic long_pending;
    } t_out_item;

    typedef struct packed {
        logic [DUR_W-1:0] debounce_time;
        logic [DUR_W-1:0] hold_time;
    } t_cfg;

endpackage

### design/bdlp_if.sv
// Valid/ready channel interfaces for input polls and result items.
// Depends on bdlp_pkg for the payload types.
interface bdlp_in_if import bdlp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/button_debounce_long_press_core.sv
// Top level of the button debounce / long-press block.
// Depends on bdlp_pkg, bdlp_if, bdlp_cfg and bdlp_step.
//
// Usage:
//   i_in  : valid/ready channel of poll items (kind, pin_level, now_ms, ack_long).
//           pin_level is active low; kind selects update poll or restart.
//   o_out : valid/ready channel of result items (is_down, press_pulse,
//           release_pulse, long_pending), exactly one per poll.
//   APB   : debounce_time at byte address 0, hold_time at 4 (16-bit each).
//           Write only while the block is idle.
// Path: an accepted item waits in the input register; its result is then held
//   in the output register and presented on o_out until it is taken.
// Throughput: one item per cycle while o_out is not stalled. The state update
//   is combinational between the input register and the result register, so
//   the next item sees the updated state with no bubble.
// Reset: synchronous, active low. Button assumed released, latch cleared,
//   debounce_time = 20, hold_time = 1000, both channel registers empty.
// Stall: when o_out.ready is low with a result waiting, the input register
//   still fills once; the block then holds i_in.ready low until the result
//   is taken.
module button_debounce_long_press_core import bdlp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bdlp_in_if.sink               i_in,
    bdlp_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_adv;
    logic      w_in_ready;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    bdlp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Output register can take a new result when empty or being drained
    assign w_adv      = !r_out_valid || o_out.ready;
    // Input register frees up when empty or when its item moves on this cycle
    assign w_in_ready = !r_in_valid || w_adv;

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    // Update button state exactly once per item, as it moves to the output
    bdlp_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (r_in_valid && w_adv),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_item <= i_in.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_out_item <= w_result;
        end
    end

endmodule

### design/bdlp_cfg.sv
// APB-style register file for debounce and hold times.
// Depends on bdlp_pkg.
module bdlp_cfg import bdlp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= DEBOUNCE_RESET;
            r_cfg.hold_time     <= HOLD_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_DEBOUNCE: r_cfg.debounce_time <= pwdata[DUR_W-1:0];
                REG_HOLD:     r_cfg.hold_time     <= pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DEBOUNCE: prdata = {{(CFG_DATA_W-DUR_W){1'b0}}, r_cfg.debounce_time};
            REG_HOLD:     prdata = {{(CFG_DATA_W-DUR_W){1'b0}}, r_cfg.hold_time};
            default:      prdata = '0;
        endcase
    end

endmodule

### design/bdlp_step.sv
// Button state and per-poll update logic: debounce, edge pulses, long-press latch.
// Depends on bdlp_pkg.
module bdlp_step import bdlp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    // The level seen before an update always equals the stable level left by
    // the previous one, so the stable register doubles as the previous level.
    logic              r_raw, n_raw;
    logic              r_stable, n_stable;
    logic [TIME_W-1:0] r_change_time, n_change_time;
    logic [TIME_W-1:0] r_press_time, n_press_time;
    logic              r_long_fired, n_long_fired;
    logic              r_long_latch, n_long_latch;

    logic              w_pressed;
    logic              w_press_p;
    logic              w_release_p;
    logic              w_fired_mid;
    logic              w_fire;
    logic              w_pending;
    logic [TIME_W-1:0] w_since_change;
    logic [TIME_W-1:0] w_since_press;

    assign w_pressed = ~i_item.pin_level;

    always_comb begin
        n_raw          = r_raw;
        n_stable       = r_stable;
        n_change_time  = r_change_time;
        n_press_time   = r_press_time;
        n_long_fired   = r_long_fired;
        n_long_latch   = r_long_latch;
        w_press_p      = 1'b0;
        w_release_p    = 1'b0;
        w_fired_mid    = r_long_fired;
        w_fire         = 1'b0;
        w_since_change = '0;
        w_since_press  = '0;

        if (t_kind'(i_item.kind) == KIND_RESTART) begin
            // Re-seed from the pin; a hold in progress never fires
            n_raw         = w_pressed;
            n_stable      = w_pressed;
            n_change_time = '0;
            n_press_time  = '0;
            n_long_latch  = 1'b0;
            n_long_fired  = w_pressed;
        end else begin
            if (w_pressed != r_raw) begin
                n_raw         = w_pressed;
                n_change_time = i_item.now_ms;
            end
            w_since_change = i_item.now_ms - n_change_time;
            if (w_since_change >= {{(TIME_W-DUR_W){1'b0}}, i_cfg.debounce_time}) begin
                n_stable = n_raw;
            end
            w_press_p   = n_stable && !r_stable;
            w_release_p = !n_stable && r_stable;
            if (w_press_p) begin
                n_press_time = i_item.now_ms;
                w_fired_mid  = 1'b0;
            end
            w_since_press = i_item.now_ms - n_press_time;
            w_fire = n_stable && !w_fired_mid &&
                     (w_since_press >= {{(TIME_W-DUR_W){1'b0}}, i_cfg.hold_time});
            n_long_fired = w_fired_mid || w_fire;
            n_long_latch = r_long_latch || w_fire;
        end

        w_pending = n_long_latch;
        // Acknowledge reports the latch, then drops it
        if (i_item.ack_long) begin
            n_long_latch = 1'b0;
        end

        o_result.is_down       = n_stable;
        o_result.press_pulse   = w_press_p;
        o_result.release_pulse = w_release_p;
        o_result.long_pending  = w_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
            r_press_time  <= '0;
            r_long_fired  <= 1'b0;
            r_long_latch  <= 1'b0;
        end else if (i_fire) begin
            r_raw         <= n_raw;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
            r_long_fired  <= n_long_fired;
            r_long_latch  <= n_long_latch;
        end
    end

endmodule
